// ===== rtl/rcs_pkg.sv =====
// Shared constants, register map and configuration type of the column ray setup block.
package rcs_pkg;

	localparam int FRAC_BITS   = 16;
	localparam int MAX_COLUMNS = 4096;

	localparam int COL_W  = 12;
	localparam int POS_W  = 31;
	localparam int VEC_W  = 18;
	localparam int WW_W   = 13;
	localparam int RAY_W  = 19;
	localparam int DIST_W = 32;
	localparam int CELL_W = 15;

	localparam int APB_AW = 5;
	localparam int APB_DW = 32;

	localparam logic [2:0] REG_POS_X       = 3'd0;
	localparam logic [2:0] REG_POS_Y       = 3'd1;
	localparam logic [2:0] REG_DIR_X       = 3'd2;
	localparam logic [2:0] REG_DIR_Y       = 3'd3;
	localparam logic [2:0] REG_PLANE_X     = 3'd4;
	localparam logic [2:0] REG_PLANE_Y     = 3'd5;
	localparam logic [2:0] REG_SCREEN_COLS = 3'd6;

	localparam int IN_TDATA_W  = ((COL_W + 7) / 8) * 8;
	localparam int OUT_BITS    = 2 * RAY_W + 4 * DIST_W + 2 * CELL_W + 2;
	localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

	typedef struct packed {
		logic        [POS_W-1:0] pos_x;
		logic        [POS_W-1:0] pos_y;
		logic signed [VEC_W-1:0] dir_x;
		logic signed [VEC_W-1:0] dir_y;
		logic signed [VEC_W-1:0] plane_x;
		logic signed [VEC_W-1:0] plane_y;
		logic        [WW_W-1:0]  screen_cols;
	} rcs_cfg_t;

endpackage

// ===== rtl/rcs_cfg.sv =====
// APB register file holding viewer position, direction, camera plane and screen width.
module rcs_cfg
	import rcs_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready,
	output rcs_cfg_t          cfg
);

	rcs_cfg_t   cfg_q;
	logic       wr;
	logic [2:0] idx;

	assign pready = 1'b1;
	assign wr     = psel & penable & pwrite & pready;
	assign idx    = paddr[4:2];
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pos_x       <= '0;
			cfg_q.pos_y       <= '0;
			cfg_q.dir_x       <= '0;
			cfg_q.dir_y       <= -18'sd65536;
			cfg_q.plane_x     <= 18'sd43254;
			cfg_q.plane_y     <= '0;
			cfg_q.screen_cols <= WW_W'(640);
		end else if (wr) begin
			unique case (idx)
				REG_POS_X:       cfg_q.pos_x       <= pwdata[POS_W-1:0];
				REG_POS_Y:       cfg_q.pos_y       <= pwdata[POS_W-1:0];
				REG_DIR_X:       cfg_q.dir_x       <= $signed(pwdata[VEC_W-1:0]);
				REG_DIR_Y:       cfg_q.dir_y       <= $signed(pwdata[VEC_W-1:0]);
				REG_PLANE_X:     cfg_q.plane_x     <= $signed(pwdata[VEC_W-1:0]);
				REG_PLANE_Y:     cfg_q.plane_y     <= $signed(pwdata[VEC_W-1:0]);
				REG_SCREEN_COLS: cfg_q.screen_cols <= pwdata[WW_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_POS_X:       prdata = APB_DW'(cfg_q.pos_x);
			REG_POS_Y:       prdata = APB_DW'(cfg_q.pos_y);
			REG_DIR_X:       prdata = APB_DW'(cfg_q.dir_x);
			REG_DIR_Y:       prdata = APB_DW'(cfg_q.dir_y);
			REG_PLANE_X:     prdata = APB_DW'(cfg_q.plane_x);
			REG_PLANE_Y:     prdata = APB_DW'(cfg_q.plane_y);
			REG_SCREEN_COLS: prdata = APB_DW'(cfg_q.screen_cols);
			default:         prdata = '0;
		endcase
	end

endmodule

// ===== rtl/rcs_udiv_pipe.sv =====
// Pipelined restoring unsigned divider, one quotient bit per stage.
module rcs_udiv_pipe
	import rcs_pkg::*;
#(
	parameter int NUM_W = 34,
	parameter int DEN_W = 18
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_valid,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             out_valid,
	output logic [NUM_W-1:0] quo
);

	logic [DEN_W-1:0] rem_s [NUM_W];
	logic [NUM_W-1:0] nq_s  [NUM_W];
	logic [DEN_W-1:0] den_s [NUM_W];
	logic [DEN_W-1:0] rem_n [NUM_W];
	logic [NUM_W-1:0] nq_n  [NUM_W];
	logic [DEN_W-1:0] den_n [NUM_W];
	logic [NUM_W-1:0] v_q;

	always_comb begin
		logic [DEN_W-1:0] r_in;
		logic [NUM_W-1:0] n_in;
		logic [DEN_W-1:0] d_in;
		logic [DEN_W:0]   shifted;
		logic [DEN_W+1:0] diff;
		for (int k = 0; k < NUM_W; k++) begin
			if (k == 0) begin
				r_in = '0;
				n_in = num;
				d_in = den;
			end else begin
				r_in = rem_s[(k == 0) ? 0 : k - 1];
				n_in = nq_s[(k == 0) ? 0 : k - 1];
				d_in = den_s[(k == 0) ? 0 : k - 1];
			end
			shifted = {r_in, n_in[NUM_W-1]};
			diff    = {1'b0, shifted} - {2'b00, d_in};
			// borrow: keep the partial remainder, quotient bit zero
			if (diff[DEN_W+1]) begin
				rem_n[k] = shifted[DEN_W-1:0];
				nq_n[k]  = {n_in[NUM_W-2:0], 1'b0};
			end else begin
				rem_n[k] = diff[DEN_W-1:0];
				nq_n[k]  = {n_in[NUM_W-2:0], 1'b1};
			end
			den_n[k] = d_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s <= rem_n;
			nq_s  <= nq_n;
			den_s <= den_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (en) begin
			v_q <= {v_q[NUM_W-2:0], in_valid};
		end
	end

	assign out_valid = v_q[NUM_W-1];
	assign quo       = nq_s[NUM_W-1];

endmodule

// ===== rtl/rcs_isqrt_pipe.sv =====
// Pipelined integer square root, one root bit per stage.
module rcs_isqrt_pipe
	import rcs_pkg::*;
#(
	parameter int RAD_W = 36
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_valid,
	input  logic [RAD_W-1:0]   rad,
	output logic               out_valid,
	output logic [RAD_W/2-1:0] root
);

	localparam int ROOT_W = RAD_W / 2;

	logic [ROOT_W:0]   rem_s [ROOT_W];
	logic [ROOT_W-1:0] rt_s  [ROOT_W];
	logic [RAD_W-1:0]  rad_s [ROOT_W];
	logic [ROOT_W:0]   rem_n [ROOT_W];
	logic [ROOT_W-1:0] rt_n  [ROOT_W];
	logic [RAD_W-1:0]  rad_n [ROOT_W];
	logic [ROOT_W-1:0] v_q;

	always_comb begin
		logic [ROOT_W:0]   r_in;
		logic [ROOT_W-1:0] t_in;
		logic [RAD_W-1:0]  a_in;
		logic [ROOT_W+1:0] shifted;
		logic [ROOT_W+1:0] trial;
		logic [ROOT_W+2:0] diff;
		for (int k = 0; k < ROOT_W; k++) begin
			if (k == 0) begin
				r_in = '0;
				t_in = '0;
				a_in = rad;
			end else begin
				r_in = rem_s[(k == 0) ? 0 : k - 1];
				t_in = rt_s[(k == 0) ? 0 : k - 1];
				a_in = rad_s[(k == 0) ? 0 : k - 1];
			end
			shifted = {r_in[ROOT_W-1:0], a_in[RAD_W-1:RAD_W-2]};
			trial   = {t_in, 2'b01};
			diff    = {1'b0, shifted} - {1'b0, trial};
			if (diff[ROOT_W+2]) begin
				rem_n[k] = shifted[ROOT_W:0];
				rt_n[k]  = {t_in[ROOT_W-2:0], 1'b0};
			end else begin
				rem_n[k] = diff[ROOT_W:0];
				rt_n[k]  = {t_in[ROOT_W-2:0], 1'b1};
			end
			rad_n[k] = {a_in[RAD_W-3:0], 2'b00};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s <= rem_n;
			rt_s  <= rt_n;
			rad_s <= rad_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (en) begin
			v_q <= {v_q[ROOT_W-2:0], in_valid};
		end
	end

	assign out_valid = v_q[ROOT_W-1];
	assign root      = rt_s[ROOT_W-1];

endmodule

// ===== rtl/rcs_delay.sv =====
// Enabled delay line that carries side data alongside a multi-stage unit.
module rcs_delay
	import rcs_pkg::*;
#(
	parameter int W     = 38,
	parameter int DEPTH = 18
) (
	input  logic         clk,
	input  logic         en,
	input  logic [W-1:0] din,
	output logic [W-1:0] dout
);

	logic [W-1:0] d_s [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			d_s[0] <= din;
			for (int k = 1; k < DEPTH; k++) begin
				d_s[k] <= d_s[k-1];
			end
		end
	end

	assign dout = d_s[DEPTH-1];

endmodule

// ===== rtl/rcs_skid.sv =====
// Output register with one skid entry; frees the pipeline from the downstream ready.
module rcs_skid
	import rcs_pkg::*;
#(
	parameter int DW = OUT_TDATA_W
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic [DW-1:0] in_data,
	output logic          adv,
	output logic          m_tvalid,
	input  logic          m_tready,
	output logic [DW-1:0] m_tdata
);

	logic          out_v_q;
	logic          skid_v_q;
	logic [DW-1:0] out_d_q;
	logic [DW-1:0] skid_d_q;

	// pipeline moves only while the skid entry is free
	assign adv      = ~skid_v_q;
	assign m_tvalid = out_v_q;
	assign m_tdata  = out_d_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (!skid_v_q) begin
			if (in_valid) begin
				if (!out_v_q || m_tready) begin
					out_v_q <= 1'b1;
				end else begin
					skid_v_q <= 1'b1;
				end
			end else if (m_tready) begin
				out_v_q <= 1'b0;
			end
		end else if (m_tready) begin
			skid_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (!skid_v_q) begin
			if (in_valid && (!out_v_q || m_tready)) begin
				out_d_q <= in_data;
			end else if (in_valid) begin
				skid_d_q <= in_data;
			end
		end else if (m_tready) begin
			out_d_q <= skid_d_q;
		end
	end

	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid entry full while output register empty");

	a_skid_fills: assert property (@(posedge clk) disable iff (!arst_n)
		(!skid_v_q && in_valid && out_v_q && !m_tready) |=> skid_v_q)
		else $error("stalled beat not captured in skid entry");

	a_skid_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(skid_v_q && m_tready) |=>
		(!skid_v_q && out_v_q && out_d_q == $past(skid_d_q)))
		else $error("skid entry not moved to output register");

endmodule

// ===== rtl/raycast_column_setup.sv =====
// Top level of the column ray setup pipeline: camera factor, ray, deltas and side distances.
//
//  channel   | dir | handshake                 | payload
//  s_*       | in  | s_tvalid / s_tready       | s_tdata: column [11:0], zero pad [15:12]
//  m_*       | out | m_tvalid / m_tready       | m_tdata: ray setup result, see port
//  APB       | in  | psel, penable, pready     | paddr 4*index, pwdata / prdata
//
//  Throughput: one column per clock while s_tready is high. The pipeline runs through the
//  bit-per-stage camera-factor divider (29), the root unit (18) and the delta dividers
//  (34), plus the stages of factor, multiply, round, ray, square, sum, divide operands,
//  saturate and side products, and the output register.
//  Reset clears every valid bit and loads the registers with their defaults at once.
//  A stalled result holds in the output register; one more beat lands in the skid
//  entry, then s_tready drops and the whole pipeline holds until the beat is taken.
module raycast_column_setup
	import rcs_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,  // [11:0] column, [15:12] zero
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// [18:0] ray_dir_x, [37:19] ray_dir_y, [69:38] delta_x, [101:70] delta_y,
	// [116:102] cell_x, [131:117] cell_y, [163:132] side_x, [195:164] side_y,
	// [196] step_x_neg, [197] step_y_neg, [199:198] zero
	output logic [OUT_TDATA_W-1:0] m_tdata,
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [APB_AW-1:0]      paddr,
	input  logic [APB_DW-1:0]      pwdata,
	output logic [APB_DW-1:0]      prdata,
	output logic                   pready
);

	localparam int Q1_W    = COL_W + FRAC_BITS + 1;   // camera factor quotient
	localparam int F_W     = Q1_W + 2;                // signed camera factor
	localparam int PROD_W  = VEC_W + F_W;             // plane * factor
	localparam int MAG_W   = PROD_W + 1 - FRAC_BITS;  // rounded magnitude
	localparam int SUM_W   = MAG_W + 2;               // dir + camera term
	localparam int RAD_W   = 2 * RAY_W - 2;           // squared length
	localparam int ROOT_W  = RAD_W / 2;
	localparam int NUM2_W  = ROOT_W + FRAC_BITS;
	localparam int DEN2_W  = RAY_W - 1;
	localparam int FR_W    = FRAC_BITS + 1;
	localparam int MUL_W   = FR_W + DIST_W;
	localparam logic signed [SUM_W-1:0] RAY_HI = SUM_W'(1 << (FRAC_BITS + 1));
	localparam logic signed [SUM_W-1:0] RAY_LO = -RAY_HI;

	// ---- helpers -------------------------------------------------------------
	// |prod| rounded half away from zero to whole fraction units
	function automatic logic [MAG_W-1:0] round_mag(input logic signed [PROD_W-1:0] p);
		logic [PROD_W-1:0] a;
		logic [PROD_W:0]   r;
		a = p[PROD_W-1] ? PROD_W'(-p) : PROD_W'(p);
		r = {1'b0, a} + (PROD_W+1)'(1 << (FRAC_BITS - 1));
		return r[PROD_W:FRAC_BITS];
	endfunction

	// direction plus signed camera term, clamped to the ray range
	function automatic logic signed [RAY_W-1:0] ray_sat(input logic signed [VEC_W-1:0] d,
			input logic [MAG_W-1:0] m, input logic neg);
		logic signed [SUM_W-1:0] cam;
		logic signed [SUM_W-1:0] tot;
		cam = $signed({2'b00, m});
		if (neg) cam = -cam;
		tot = cam + $signed({{(SUM_W-VEC_W){d[VEC_W-1]}}, d});
		if (tot > RAY_HI) tot = RAY_HI;
		if (tot < RAY_LO) tot = RAY_LO;
		return tot[RAY_W-1:0];
	endfunction

	function automatic logic [RAD_W-1:0] square(input logic signed [RAY_W-1:0] v);
		logic signed [2*RAY_W-1:0] p;
		p = v * v;
		return p[RAD_W-1:0];
	endfunction

	function automatic logic [DEN2_W-1:0] mag_of(input logic signed [RAY_W-1:0] v);
		logic [RAY_W-1:0] m;
		m = v[RAY_W-1] ? RAY_W'(-v) : RAY_W'(v);
		return m[DEN2_W-1:0];
	endfunction

	// zero component or quotient above 32 bits saturates
	function automatic logic [DIST_W-1:0] delta_sat(input logic [NUM2_W-1:0] q,
			input logic signed [RAY_W-1:0] v);
		if (v == '0 || q[NUM2_W-1:DIST_W] != '0) return '1;
		return q[DIST_W-1:0];
	endfunction

	// distance to the first grid side, in fraction units
	function automatic logic [FR_W-1:0] first_dist(input logic [POS_W-1:0] pos,
			input logic signed [RAY_W-1:0] v);
		logic [FR_W-1:0] fr;
		fr = {1'b0, pos[FRAC_BITS-1:0]};
		return v[RAY_W-1] ? fr : FR_W'(1 << FRAC_BITS) - fr;
	endfunction

	// ---- configuration -------------------------------------------------------
	rcs_cfg_t cfg;

	rcs_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// ---- input and camera-factor divide --------------------------------------
	logic              adv;
	logic [COL_W-1:0]  col_in;
	logic [COL_W-1:0]  col_c;
	logic [WW_W-1:0]   width_c;
	logic              q_v;
	logic [Q1_W-1:0]   q;

	assign s_tready = adv;
	assign col_in   = s_tdata[COL_W-1:0];
	// clamp columns past the table size; a zero width acts as one
	assign col_c    = (32'(col_in) >= 32'(MAX_COLUMNS)) ? COL_W'(MAX_COLUMNS - 1) : col_in;
	assign width_c  = (cfg.screen_cols == '0) ? WW_W'(1) : cfg.screen_cols;

	rcs_udiv_pipe #(.NUM_W(Q1_W), .DEN_W(WW_W)) u_fdiv (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (s_tvalid),
		.num       ({col_c, {(FRAC_BITS+1){1'b0}}}),
		.den       (width_c),
		.out_valid (q_v),
		.quo       (q)
	);

	// ---- stages 1..6: factor, product, round, ray, squares, sum --------------
	logic                     v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic signed [F_W-1:0]    f_s1;
	logic signed [PROD_W-1:0] prod_x_s2, prod_y_s2;
	logic [MAG_W-1:0]         mag_x_s3, mag_y_s3;
	logic                     neg_x_s3, neg_y_s3;
	logic signed [RAY_W-1:0]  rx_s4, ry_s4, rx_s5, ry_s5, rx_s6, ry_s6;
	logic [RAD_W-1:0]         sq_x_s5, sq_y_s5, sum_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (adv) begin
			v_s1 <= q_v;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			f_s1      <= $signed({2'b00, q}) - $signed(F_W'(1 << FRAC_BITS));
			prod_x_s2 <= $signed(cfg.plane_x) * f_s1;
			prod_y_s2 <= $signed(cfg.plane_y) * f_s1;
			mag_x_s3  <= round_mag(prod_x_s2);
			mag_y_s3  <= round_mag(prod_y_s2);
			neg_x_s3  <= prod_x_s2[PROD_W-1];
			neg_y_s3  <= prod_y_s2[PROD_W-1];
			rx_s4     <= ray_sat(cfg.dir_x, mag_x_s3, neg_x_s3);
			ry_s4     <= ray_sat(cfg.dir_y, mag_y_s3, neg_y_s3);
			sq_x_s5   <= square(rx_s4);
			sq_y_s5   <= square(ry_s4);
			rx_s5     <= rx_s4;
			ry_s5     <= ry_s4;
			sum_s6    <= sq_x_s5 + sq_y_s5;
			rx_s6     <= rx_s5;
			ry_s6     <= ry_s5;
		end
	end

	// ---- ray length ----------------------------------------------------------
	logic                    len_v;
	logic [ROOT_W-1:0]       len;
	logic [2*RAY_W-1:0]      rxy_a;

	rcs_isqrt_pipe #(.RAD_W(RAD_W)) u_len (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (v_s6),
		.rad       (sum_s6),
		.out_valid (len_v),
		.root      (len)
	);

	rcs_delay #(.W(2 * RAY_W), .DEPTH(ROOT_W)) u_dly_len (
		.clk  (clk),
		.en   (adv),
		.din  ({ry_s6, rx_s6}),
		.dout (rxy_a)
	);

	// ---- stage 7: divide operands --------------------------------------------
	logic                    v_s7;
	logic [NUM2_W-1:0]       num_s7;
	logic [DEN2_W-1:0]       ax_s7, ay_s7;
	logic signed [RAY_W-1:0] rx_s7, ry_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0;
		end else if (adv) begin
			v_s7 <= len_v;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			num_s7 <= {len, {FRAC_BITS{1'b0}}};
			ax_s7  <= mag_of($signed(rxy_a[RAY_W-1:0]));
			ay_s7  <= mag_of($signed(rxy_a[2*RAY_W-1:RAY_W]));
			rx_s7  <= $signed(rxy_a[RAY_W-1:0]);
			ry_s7  <= $signed(rxy_a[2*RAY_W-1:RAY_W]);
		end
	end

	// ---- delta divides -------------------------------------------------------
	logic                qx_v, qy_v;
	logic [NUM2_W-1:0]   qx, qy;
	logic [2*RAY_W-1:0]  rxy_b;

	rcs_udiv_pipe #(.NUM_W(NUM2_W), .DEN_W(DEN2_W)) u_xdiv (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (v_s7),
		.num       (num_s7),
		.den       (ax_s7),
		.out_valid (qx_v),
		.quo       (qx)
	);

	rcs_udiv_pipe #(.NUM_W(NUM2_W), .DEN_W(DEN2_W)) u_ydiv (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (v_s7),
		.num       (num_s7),
		.den       (ay_s7),
		.out_valid (qy_v),
		.quo       (qy)
	);

	rcs_delay #(.W(2 * RAY_W), .DEPTH(NUM2_W)) u_dly_div (
		.clk  (clk),
		.en   (adv),
		.din  ({ry_s7, rx_s7}),
		.dout (rxy_b)
	);

	// ---- stages 8, 9: saturate deltas, side products -------------------------
	logic                    v_s8, v_s9;
	logic [DIST_W-1:0]       delta_x_s8, delta_y_s8, delta_x_s9, delta_y_s9;
	logic [FR_W-1:0]         dist_x_s8, dist_y_s8;
	logic signed [RAY_W-1:0] rx_s8, ry_s8, rx_s9, ry_s9;
	logic [MUL_W-1:0]        mul_x_s9, mul_y_s9;
	logic                    dz_x_s9, dz_y_s9;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s8 <= 1'b0;
			v_s9 <= 1'b0;
		end else if (adv) begin
			v_s8 <= qx_v & qy_v;
			v_s9 <= v_s8;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rx_s8      <= $signed(rxy_b[RAY_W-1:0]);
			ry_s8      <= $signed(rxy_b[2*RAY_W-1:RAY_W]);
			delta_x_s8 <= delta_sat(qx, $signed(rxy_b[RAY_W-1:0]));
			delta_y_s8 <= delta_sat(qy, $signed(rxy_b[2*RAY_W-1:RAY_W]));
			dist_x_s8  <= first_dist(cfg.pos_x, $signed(rxy_b[RAY_W-1:0]));
			dist_y_s8  <= first_dist(cfg.pos_y, $signed(rxy_b[2*RAY_W-1:RAY_W]));
			mul_x_s9   <= MUL_W'(dist_x_s8) * MUL_W'(delta_x_s8);
			mul_y_s9   <= MUL_W'(dist_y_s8) * MUL_W'(delta_y_s8);
			dz_x_s9    <= (dist_x_s8 == '0);
			dz_y_s9    <= (dist_y_s8 == '0);
			delta_x_s9 <= delta_x_s8;
			delta_y_s9 <= delta_y_s8;
			rx_s9      <= rx_s8;
			ry_s9      <= ry_s8;
		end
	end

	// ---- result select and pack ----------------------------------------------
	logic [DIST_W-1:0]      side_x, side_y;
	logic [CELL_W-1:0]      cell_x, cell_y;
	logic [OUT_TDATA_W-1:0] res_data;

	// side is zero when a negative ray starts on an exact grid line, saturates with its delta
	assign side_x = dz_x_s9 ? '0 : (delta_x_s9 == '1) ? '1 :
		mul_x_s9[FRAC_BITS+DIST_W-1:FRAC_BITS];
	assign side_y = dz_y_s9 ? '0 : (delta_y_s9 == '1) ? '1 :
		mul_y_s9[FRAC_BITS+DIST_W-1:FRAC_BITS];
	assign cell_x = cfg.pos_x[FRAC_BITS+CELL_W-1:FRAC_BITS];
	assign cell_y = cfg.pos_y[FRAC_BITS+CELL_W-1:FRAC_BITS];

	assign res_data = {{(OUT_TDATA_W-OUT_BITS){1'b0}}, ry_s9[RAY_W-1], rx_s9[RAY_W-1],
		side_y, side_x, cell_y, cell_x, delta_y_s9, delta_x_s9, ry_s9, rx_s9};

	rcs_skid #(.DW(OUT_TDATA_W)) u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (v_s9),
		.in_data  (res_data),
		.adv      (adv),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule
